>>> hdl/trapezoid_velocity_profile_macros.svh
// Assertion macros for the trapezoid velocity profile block.
// Used by the top level; expects clk and rst in scope.
`ifndef TRAPEZOID_VELOCITY_PROFILE_MACROS_SVH
`define TRAPEZOID_VELOCITY_PROFILE_MACROS_SVH

// same-cycle implication
`define TVP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvp assertion failed");

// next-cycle implication
`define TVP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvp assertion failed");

`endif

>>> hdl/tvp_pkg.sv
// Package for the trapezoid velocity profile block: payload structs, codes, widths.
// No dependencies.
`timescale 1ns / 1ps

package tvp_pkg;

  localparam int MUL_W     = 33;
  localparam int MUL_CNT_W = 6;
  localparam int DIV_N     = 80;
  localparam int DIV_D     = 32;
  localparam int DIV_CNT_W = 7;

  localparam logic       KIND_PLAN   = 1'b0;
  localparam logic       KIND_TICK   = 1'b1;
  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_PLANNED  = 2'd2;
  localparam logic       REG_ACCEL   = 1'b0;
  localparam logic       REG_TICK    = 1'b1;

  localparam logic [31:0] ACCEL_RESET = 32'd65536000;
  localparam logic [31:0] TICK_RESET  = 32'd16777;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] start_pos;
    logic signed [31:0] end_pos;
    logic [30:0]        vel_limit;
  } tvp_in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic [1:0]         status;
  } tvp_out_t;

endpackage

>>> hdl/tvp_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on tvp_pkg.
`timescale 1ns / 1ps

module tvp_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tvp_pkg::MUL_W-1:0]     op_a,
  input  logic [tvp_pkg::MUL_W-1:0]     op_b,
  output logic                          done,
  output logic [2*tvp_pkg::MUL_W-1:0]   product
);
  import tvp_pkg::*;

  logic [MUL_W-1:0]     acc;
  logic [MUL_W-1:0]     mcand;
  logic [MUL_W-1:0]     mplier;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic [MUL_W:0]       sum;

  assign sum     = {1'b0, acc} + (mplier[0] ? {1'b0, mcand} : '0);
  assign product = {acc, mplier};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        acc    <= '0;
        mcand  <= op_a;
        mplier <= op_b;
        cnt    <= '0;
      end else if (busy) begin
        acc    <= sum[MUL_W:1];
        mplier <= {sum[0], mplier[MUL_W-1:1]};
        cnt    <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/tvp_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on tvp_pkg.
`timescale 1ns / 1ps

module tvp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tvp_pkg::DIV_N-1:0]   dividend,
  input  logic [tvp_pkg::DIV_D-1:0]   divisor,
  output logic                        done,
  output logic [tvp_pkg::DIV_N-1:0]   quotient
);
  import tvp_pkg::*;

  logic [DIV_D-1:0]     rem;
  logic [DIV_D-1:0]     dvs;
  logic [DIV_N-1:0]     sh;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_D:0]       trial;
  logic [DIV_D:0]       diff;
  logic                 ge;

  assign trial    = {rem, sh[DIV_N-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        dvs  <= divisor;
        sh   <= dividend;
        cnt  <= '0;
      end else if (busy) begin
        // remainder stays below the divisor, so DIV_D bits hold it
        rem <= ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
        sh  <= {sh[DIV_N-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/trapezoid_velocity_profile.sv
// Trapezoid velocity profile generator: one result per transaction, plan or tick.
// A plan runs two serial divides and three serial multiplies; when no cruise phase
// fits it adds a third divide, a square root and a fourth multiply. A tick runs one
// multiply in the cruise phase and two in the ramps; a finished tick runs none.
// Depends on tvp_pkg, tvp_mul, tvp_div and the macros.
`timescale 1ns / 1ps
`include "trapezoid_velocity_profile_macros.svh"

module trapezoid_velocity_profile (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  tvp_pkg::tvp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tvp_pkg::tvp_out_t out_data
);
  import tvp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_TA, S_Q, S_CMP, S_TOT, S_TRI, S_SQRT, S_PEAK, S_R1, S_R2, S_CV,
    S_TCASE, S_A1, S_A2, S_B, S_C1, S_C2, S_TFIN, S_EMIT
  } state_t;

  state_t state;

  logic [31:0] accel_cfg, tick_cfg;
  logic [31:0] elapsed, ramp_time, total_time, plan_accel, mag;
  logic [32:0] cruise_time;
  logic [30:0] peak, vel_lim, vm;
  logic        move_dir;
  logic [31:0] origin_pos, target_pos;
  logic [55:0] ta;
  logic [56:0] qv;
  logic [37:0] ramp_dist;
  logic [39:0] cruise_dist;
  logic [31:0] t_cur, t_rel, tau;
  logic [40:0] travel;
  logic        op_run;
  tvp_out_t    res;

  logic [63:0] sq_x;
  logic [32:0] sq_rem;
  logic [31:0] sq_root;
  logic [4:0]  sq_cnt;
  logic [34:0] sq_r, sq_trial, sq_diff;
  logic        sq_ge;

  logic              mul_start, mul_done, div_start, div_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic [DIV_N-1:0]  div_num, div_q;
  logic [DIV_D-1:0]  div_den;
  logic              mul_state, div_state;

  logic [32:0] dp, esum;
  logic [56:0] q_minus_ta;
  logic [34:0] tsum;
  logic [31:0] vm_sum, d32, vel32;

  assign in_stall = (state != S_IDLE);

  assign dp         = {in_data.end_pos[31], in_data.end_pos}
                    - {in_data.start_pos[31], in_data.start_pos};
  assign esum       = {1'b0, elapsed} + {1'b0, tick_cfg};
  assign q_minus_ta = qv - {1'b0, ta};
  assign tsum       = {2'b0, cruise_time} + {2'b0, ramp_time, 1'b0};
  assign vm_sum     = {1'b0, vm} + {1'b0, peak};
  assign d32        = (travel > {9'b0, mag}) ? mag : travel[31:0];
  assign vel32      = {1'b0, vm};

  // square root: two radicand bits per cycle
  assign sq_r     = {sq_rem, sq_x[63:62]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_ge    = sq_r >= sq_trial;
  assign sq_diff  = sq_r - sq_trial;

  assign mul_state = (state == S_PEAK) || (state == S_R1) || (state == S_R2) ||
                     (state == S_CV) || (state == S_A1) || (state == S_A2) ||
                     (state == S_B) || (state == S_C1) || (state == S_C2);
  assign div_state = (state == S_TA) || (state == S_Q) || (state == S_TRI);
  assign mul_start = mul_state && !op_run;
  assign div_start = div_state && !op_run;

  always_comb begin
    unique case (state)
      S_PEAK, S_R1: begin mul_a = {1'b0, plan_accel}; mul_b = {1'b0, ramp_time}; end
      S_R2:         begin mul_a = {2'b0, vm};         mul_b = {1'b0, ramp_time}; end
      S_CV:         begin mul_a = {2'b0, peak};       mul_b = cruise_time; end
      S_A1:         begin mul_a = {1'b0, plan_accel}; mul_b = {1'b0, t_cur}; end
      S_A2:         begin mul_a = {2'b0, vm};         mul_b = {1'b0, t_cur}; end
      S_B:          begin mul_a = {2'b0, peak};       mul_b = {1'b0, t_rel}; end
      S_C1:         begin mul_a = {1'b0, plan_accel}; mul_b = {1'b0, tau}; end
      S_C2:         begin mul_a = {1'b0, vm_sum};     mul_b = {1'b0, tau}; end
      default:      begin mul_a = '0;                 mul_b = '0; end
    endcase
  end

  always_comb begin
    unique case (state)
      S_TA:    begin div_num = {25'b0, vel_lim, 24'b0}; div_den = plan_accel; end
      S_Q:     begin div_num = {24'b0, mag, 24'b0};     div_den = {1'b0, vel_lim}; end
      S_TRI:   begin div_num = {mag, 48'b0};            div_den = plan_accel; end
      default: begin div_num = '0;                      div_den = '0; end
    endcase
  end

  tvp_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
    .done(mul_done), .product(prod)
  );

  tvp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num), .divisor(div_den),
    .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op_run      <= 1'b0;
      out_valid   <= 1'b0;
      accel_cfg   <= ACCEL_RESET;
      tick_cfg    <= TICK_RESET;
      elapsed     <= '0;
      ramp_time   <= '0;
      cruise_time <= '0;
      total_time  <= '0;
      peak        <= '0;
      move_dir    <= 1'b0;
      origin_pos  <= '0;
      target_pos  <= '0;
      plan_accel  <= '0;
      mag         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACCEL: accel_cfg <= cfg_data;
          REG_TICK:  tick_cfg  <= cfg_data;
          default:   ;
        endcase
      end
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.kind == KIND_PLAN) begin
              vel_lim    <= (in_data.vel_limit == '0) ? 31'd1 : in_data.vel_limit;
              plan_accel <= (accel_cfg == '0) ? 32'd1 : accel_cfg;
              move_dir   <= dp[32];
              mag        <= dp[32] ? 32'(-dp) : dp[31:0];
              origin_pos <= in_data.start_pos;
              target_pos <= in_data.end_pos;
              elapsed    <= '0;
              res        <= '{position: in_data.start_pos, velocity: '0,
                              status: ST_PLANNED};
              state      <= S_TA;
            end else begin
              t_cur   <= elapsed;
              elapsed <= esum[32] ? 32'hFFFF_FFFF : esum[31:0];
              if (elapsed >= total_time) begin
                res   <= '{position: target_pos, velocity: '0, status: ST_FINISHED};
                state <= S_EMIT;
              end else begin
                state <= S_TCASE;
              end
            end
          end
        end

        S_TA: begin
          if (!op_run) op_run <= 1'b1;
          else if (div_done) begin
            op_run <= 1'b0;
            ta     <= div_q[55:0];
            state  <= S_Q;
          end
        end

        S_Q: begin
          if (!op_run) op_run <= 1'b1;
          else if (div_done) begin
            op_run <= 1'b0;
            qv     <= div_q[56:0];
            state  <= S_CMP;
          end
        end

        S_CMP: begin
          if (qv > {1'b0, ta}) begin
            ramp_time   <= (|ta[55:32]) ? 32'hFFFF_FFFF : ta[31:0];
            cruise_time <= (|q_minus_ta[56:33]) ? 33'h1_FFFF_FFFF : q_minus_ta[32:0];
            peak        <= vel_lim;
            state       <= S_TOT;
          end else begin
            state <= S_TRI;
          end
        end

        S_TOT: begin
          total_time <= (|tsum[34:32]) ? 32'hFFFF_FFFF : tsum[31:0];
          state      <= S_R1;
        end

        S_TRI: begin
          if (!op_run) op_run <= 1'b1;
          else if (div_done) begin
            op_run <= 1'b0;
            // quotient beyond 64 bits: root saturates
            if (|div_q[79:64]) begin
              ramp_time <= 32'hFFFF_FFFF;
              state     <= S_PEAK;
            end else begin
              sq_x    <= div_q[63:0];
              sq_rem  <= '0;
              sq_root <= '0;
              sq_cnt  <= '0;
              state   <= S_SQRT;
            end
          end
        end

        S_SQRT: begin
          sq_x    <= {sq_x[61:0], 2'b00};
          sq_rem  <= sq_ge ? sq_diff[32:0] : sq_r[32:0];
          sq_root <= {sq_root[30:0], sq_ge};
          sq_cnt  <= sq_cnt + 1'b1;
          if (sq_cnt == 5'd31) begin
            ramp_time <= {sq_root[30:0], sq_ge};
            state     <= S_PEAK;
          end
        end

        S_PEAK: begin
          if (!op_run) op_run <= 1'b1;
          else if (mul_done) begin
            op_run      <= 1'b0;
            peak        <= (|prod[65:55]) ? 31'h7FFF_FFFF : prod[54:24];
            cruise_time <= '0;
            total_time  <= ramp_time[31] ? 32'hFFFF_FFFF : {ramp_time[30:0], 1'b0};
            state       <= S_R1;
          end
        end

        S_R1: begin
          if (!op_run) op_run <= 1'b1;
          else if (mul_done) begin
            op_run <= 1'b0;
            vm     <= (|prod[65:55] || prod[54:24] > peak) ? peak : prod[54:24];
            state  <= S_R2;
          end
        end

        S_R2: begin
          if (!op_run) op_run <= 1'b1;
          else if (mul_done) begin
            op_run    <= 1'b0;
            ramp_dist <= prod[62:25];
            state     <= S_CV;
          end
        end

        S_CV: begin
          if (!op_run) op_run <= 1'b1;
          else if (mul_done) begin
            op_run      <= 1'b0;
            cruise_dist <= prod[63:24];
            state       <= S_EMIT;
          end
        end

        S_TCASE: begin
          t_rel <= t_cur - ramp_time;
          if (t_cur <= ramp_time) begin
            state <= S_A1;
          end else if ({1'b0, t_cur - ramp_time} <= cruise_time) begin
            vm    <= peak;
            state <= S_B;
          end else begin
            tau   <= t_cur - ramp_time - cruise_time[31:0];
            state <= S_C1;
          end
        end

        S_A1: begin
          if (!op_run) op_run <= 1'b1;
          else if (mul_done) begin
            op_run <= 1'b0;
            vm     <= (|prod[65:55] || prod[54:24] > peak) ? peak : prod[54:24];
            state  <= S_A2;
          end
        end

        S_A2: begin
          if (!op_run) op_run <= 1'b1;
          else if (mul_done) begin
            op_run <= 1'b0;
            travel <= {3'b0, prod[62:25]};
            state  <= S_TFIN;
          end
        end

        S_B: begin
          if (!op_run) op_run <= 1'b1;
          else if (mul_done) begin
            op_run <= 1'b0;
            travel <= {3'b0, ramp_dist} + {2'b0, prod[62:24]};
            state  <= S_TFIN;
          end
        end

        S_C1: begin
          if (!op_run) op_run <= 1'b1;
          else if (mul_done) begin
            op_run <= 1'b0;
            // deceleration past the peak clamps to standstill
            vm     <= (|prod[65:55] || prod[54:24] >= peak) ? '0 : peak - prod[54:24];
            state  <= S_C2;
          end
        end

        S_C2: begin
          if (!op_run) op_run <= 1'b1;
          else if (mul_done) begin
            op_run <= 1'b0;
            travel <= {3'b0, ramp_dist} + {1'b0, cruise_dist} + {2'b0, prod[63:25]};
            state  <= S_TFIN;
          end
        end

        S_TFIN: begin
          res.position <= move_dir ? origin_pos - d32 : origin_pos + d32;
          res.velocity <= move_dir ? -vel32 : vel32;
          res.status   <= ST_RUNNING;
          state        <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `TVP_ASSERT_IMP(a_plan_vel_zero, out_valid && out_data.status == ST_PLANNED, out_data.velocity == '0)
  `TVP_ASSERT_IMP(a_fin_vel_zero, out_valid && out_data.status == ST_FINISHED, out_data.velocity == '0)
  `TVP_ASSERT_NXT(a_elapsed_mono, !(in_valid && !in_stall && in_data.kind == KIND_PLAN), elapsed >= $past(elapsed))

endmodule
